// ----- src/cebc_pkg.sv -----
// shared types, constants and escape tables for the colon escape byte codec
`default_nettype none
package cebc_pkg;

   typedef logic [7:0] byte_type;

   // direction register codes
   typedef enum logic {
      DIR_ENCODE = 1'b0,
      DIR_DECODE = 1'b1
   } dir_type;

   // configuration register indexes
   localparam int unsigned REG_DIRECTION = 0;
   localparam int unsigned REG_COUNT     = 1;
   localparam int unsigned CSR_ADDR_W    = 3;

   localparam byte_type CHAR_COLON = 8'h3A;
   localparam byte_type CHAR_CARET = 8'h5E;
   localparam byte_type CHAR_LF    = 8'h0A;
   localparam byte_type CHAR_CR    = 8'h0D;
   localparam byte_type CHAR_DEL   = 8'h7F;
   localparam byte_type CHAR_FF    = 8'hFF;
   localparam byte_type CHAR_ZERO  = 8'h30;
   localparam byte_type CHAR_NINE  = 8'h39;
   localparam byte_type CHAR_A     = 8'h41;
   localparam byte_type CHAR_B     = 8'h42;
   localparam byte_type CHAR_C     = 8'h43;
   localparam byte_type CHAR_D     = 8'h44;
   localparam byte_type CHAR_E     = 8'h45;

   typedef struct packed {
      logic     hit;
      byte_type value;
   } esc_type;

   // encode side: raw byte to code character
   function automatic esc_type escape_code(input byte_type b);
      esc_type r;
      r.hit   = 1'b1;
      r.value = CHAR_COLON;
      if (b == CHAR_COLON) begin
         r.value = CHAR_COLON;
      end else if (b <= 8'h09) begin
         r.value = CHAR_ZERO + b;
      end else begin
         case (b)
            CHAR_LF:    r.value = CHAR_A;
            CHAR_CR:    r.value = CHAR_B;
            CHAR_CARET: r.value = CHAR_C;
            CHAR_DEL:   r.value = CHAR_D;
            CHAR_FF:    r.value = CHAR_E;
            default:    r.hit   = 1'b0;
         endcase
      end
      return r;
   endfunction

   // decode side: code character to raw byte
   function automatic esc_type unescape_code(input byte_type c);
      esc_type r;
      r.hit   = 1'b1;
      r.value = CHAR_COLON;
      if (c == CHAR_COLON) begin
         r.value = CHAR_COLON;
      end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         r.value = c - CHAR_ZERO;
      end else begin
         case (c)
            CHAR_A:  r.value = CHAR_LF;
            CHAR_B:  r.value = CHAR_CR;
            CHAR_C:  r.value = CHAR_CARET;
            CHAR_D:  r.value = CHAR_DEL;
            CHAR_E:  r.value = CHAR_FF;
            default: r.hit   = 1'b0;
         endcase
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- src/colon_escape_byte_codec.sv -----
// colon escape byte codec: encode with line wrapping, decode with line-feed removal
//
// usage
//   req channel (req_valid/req_ready) carries one input item: data_byte plus
//   message_end. rsp channel (rsp_valid/rsp_ready) carries the produced bytes,
//   one per item, run_last high on the final byte caused by an input item.
//   an input item may produce zero to three result items (line feed, colon,
//   code in encode; zero or one byte in decode).
//   direction is written through the apb-style port at byte address 0
//   (0 encode, 1 decode); write it only while the codec is idle.
// pipeline and throughput
//   three register stages: input register, expansion buffer, result register.
//   an accepted item passes the input register, then the expansion buffer, before
//   its first byte raises rsp_valid. the result register drains one byte per cycle
//   while rsp_ready is high; the next item may wait in the input register meanwhile.
// reset
//   synchronous active-high reset empties all stages, clears the line
//   counter and the pending colon, and selects encode.
// stall
//   when rsp_ready is low the result register holds; the expansion buffer and
//   the input register still fill, then req_ready drops until space frees up.
`default_nettype none
module colon_escape_byte_codec #(
   parameter int unsigned LINE_LEN = 64
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // input channel
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire cebc_pkg::byte_type               req_data_byte,
   input  wire logic                             req_message_end,
   // result channel
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output cebc_pkg::byte_type                    rsp_out_byte,
   output logic                                  rsp_run_last,
   // configuration port
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [cebc_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [31:0]                      pwdata,
   output logic [31:0]                           prdata,
   output logic                                  pready
);
   import cebc_pkg::*;

   // line length as a 7-bit compare value, matching the counter width
   localparam logic [6:0] LineLen = 7'(LINE_LEN);
   localparam logic [6:0] CountMax = 7'h7F;

   // configuration
   dir_type direction_ff, direction_in;
   logic    csr_write;
   logic    csr_hit;

   // codec state
   logic [6:0] line_count_ff, line_count_in;
   logic       colon_pending_ff, colon_pending_in;

   // input register
   logic     in_valid_ff, in_valid_in;
   byte_type in_byte_ff, in_byte_in;
   logic     in_end_ff, in_end_in;

   // expansion buffer: entry 0 is next out, shifted down as bytes leave
   byte_type   hold_byte_ff [3];
   byte_type   hold_byte_in [3];
   logic [1:0] hold_cnt_ff, hold_cnt_in;

   // result register
   logic     rsp_valid_ff, rsp_valid_in;
   byte_type rsp_byte_ff, rsp_byte_in;
   logic     rsp_last_ff, rsp_last_in;

   // handshake helpers
   logic out_take;
   logic hold_move;
   logic hold_free;
   logic in_move;

   // expansion result of the item in the input register
   byte_type   exp_byte [3];
   logic [1:0] exp_cnt;
   logic [6:0] exp_line_count;
   logic       exp_colon_pending;

   // ---------------------------------------------------------------------
   // configuration port: register index sits in paddr bit 2 and above
   // ---------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_hit   = (paddr[CSR_ADDR_W-1:2] == 1'(REG_DIRECTION));

   always_comb begin
      direction_in = direction_ff;
      if (csr_write && csr_hit) begin
         direction_in = dir_type'(pwdata[0]);
      end
   end

   always_comb begin
      prdata = '0;
      if (csr_hit) begin
         prdata[0] = direction_ff;
      end
   end

   // ---------------------------------------------------------------------
   // flow control: result register drains the buffer one byte a cycle unless stalled;
   // the buffer takes a new expansion once its last byte is leaving
   // ---------------------------------------------------------------------
   assign out_take  = !rsp_valid_ff || rsp_ready;
   assign hold_move = (hold_cnt_ff != 2'd0) && out_take;
   assign hold_free = (hold_cnt_ff == 2'd0) || ((hold_cnt_ff == 2'd1) && out_take);
   assign in_move   = in_valid_ff && hold_free;
   assign req_ready = !in_valid_ff || hold_free;

   // ---------------------------------------------------------------------
   // expansion of one item
   // ---------------------------------------------------------------------
   always_comb begin
      esc_type    enc;
      esc_type    dec;
      byte_type   s0;
      byte_type   s1;
      logic [6:0] lc_one;
      logic [6:0] lc_two;

      enc    = escape_code(in_byte_ff);
      dec    = unescape_code(in_byte_ff);
      s0     = enc.hit ? CHAR_COLON : in_byte_ff;
      s1     = enc.value;
      lc_one = (line_count_ff == CountMax) ? CountMax : line_count_ff + 7'd1;
      lc_two = (lc_one == CountMax) ? CountMax : lc_one + 7'd1;

      exp_byte[0]       = in_byte_ff;
      exp_byte[1]       = s1;
      exp_byte[2]       = s1;
      exp_cnt           = 2'd0;
      exp_line_count    = line_count_ff;
      exp_colon_pending = colon_pending_ff;

      if (direction_ff == DIR_ENCODE) begin
         if (line_count_ff >= LineLen) begin
            // line full: line feed first, at most one per item
            exp_byte[0]    = CHAR_LF;
            exp_byte[1]    = s0;
            exp_byte[2]    = s1;
            exp_cnt        = enc.hit ? 2'd3 : 2'd2;
            exp_line_count = enc.hit ? 7'd2 : 7'd1;
         end else if (!enc.hit) begin
            exp_byte[0]    = s0;
            exp_cnt        = 2'd1;
            exp_line_count = lc_one;
         end else if (lc_one >= LineLen) begin
            // colon fills the line, code byte wraps
            exp_byte[0]    = s0;
            exp_byte[1]    = CHAR_LF;
            exp_byte[2]    = s1;
            exp_cnt        = 2'd3;
            exp_line_count = 7'd1;
         end else begin
            exp_byte[0]    = s0;
            exp_byte[1]    = s1;
            exp_cnt        = 2'd2;
            exp_line_count = lc_two;
         end
      end else if (in_byte_ff != CHAR_LF) begin
         // line feeds vanish and leave a pending colon pending
         if (colon_pending_ff) begin
            exp_colon_pending = 1'b0;
            exp_byte[0]       = dec.value;
            exp_cnt           = dec.hit ? 2'd1 : 2'd0;
         end else if (in_byte_ff == CHAR_COLON) begin
            exp_colon_pending = 1'b1;
         end else begin
            exp_byte[0] = in_byte_ff;
            exp_cnt     = 2'd1;
         end
      end

      if (in_end_ff) begin
         exp_line_count    = '0;
         exp_colon_pending = 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // next values
   // ---------------------------------------------------------------------
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_end_in   = in_end_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
      end
      if (req_valid && req_ready) begin
         in_byte_in = req_data_byte;
         in_end_in  = req_message_end;
      end
   end

   always_comb begin
      line_count_in    = line_count_ff;
      colon_pending_in = colon_pending_ff;
      if (in_move) begin
         line_count_in    = exp_line_count;
         colon_pending_in = exp_colon_pending;
      end
   end

   always_comb begin
      hold_byte_in = hold_byte_ff;
      hold_cnt_in  = hold_cnt_ff;
      if (in_move) begin
         hold_byte_in = exp_byte;
         hold_cnt_in  = exp_cnt;
      end else if (hold_move) begin
         hold_byte_in[0] = hold_byte_ff[1];
         hold_byte_in[1] = hold_byte_ff[2];
         hold_cnt_in     = hold_cnt_ff - 2'd1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_take) begin
         rsp_valid_in = (hold_cnt_ff != 2'd0);
         rsp_byte_in  = hold_byte_ff[0];
         rsp_last_in  = (hold_cnt_ff == 2'd1);
      end
   end

   // ---------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff     <= DIR_ENCODE;
         line_count_ff    <= '0;
         colon_pending_ff <= 1'b0;
         in_valid_ff      <= 1'b0;
         hold_cnt_ff      <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         direction_ff     <= direction_in;
         line_count_ff    <= line_count_in;
         colon_pending_ff <= colon_pending_in;
         in_valid_ff      <= in_valid_in;
         hold_cnt_ff      <= hold_cnt_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      in_byte_ff   <= in_byte_in;
      in_end_ff    <= in_end_in;
      hold_byte_ff <= hold_byte_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_run_last = rsp_last_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   // an accepted item lands in the input register
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> in_valid_ff && in_byte_ff == $past(req_data_byte))
      else $error("accepted item not captured");

   // a blocked input register keeps its item
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !in_move |=> in_valid_ff && $stable(in_byte_ff) && $stable(in_end_ff))
      else $error("input register lost a blocked item");

   // decode never produces more than one byte per item
   assert property (@(posedge clock) disable iff (reset)
      in_move && direction_ff == DIR_DECODE |-> exp_cnt <= 2'd1)
      else $error("decode expansion too long");

   // encode always produces at least one byte per item
   assert property (@(posedge clock) disable iff (reset)
      in_move && direction_ff == DIR_ENCODE |-> exp_cnt != 2'd0)
      else $error("encode item produced nothing");

   // buffered bytes reach the result register when it frees up
   assert property (@(posedge clock) disable iff (reset)
      hold_cnt_ff != 2'd0 && out_take |=> rsp_valid_ff)
      else $error("buffered byte not forwarded");

endmodule
`default_nettype wire

// ----- dv/tb_colon_escape_byte_codec.sv -----
// self-checking testbench for the colon escape byte codec: directed table, then random messages
`default_nettype none
module tb_colon_escape_byte_codec;
   import cebc_pkg::*;

   localparam int unsigned LINE_LEN      = 64;
   // idle time after the expectation queue empties, so items with no result also pass through
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned CYCLE_LIMIT   = 100000;
   localparam int unsigned IDLE_PCT      = 27;
   localparam int unsigned NUM_DIRECTED  = 24;

   // one produced byte as seen on the result channel
   typedef struct packed {
      byte_type out_byte;
      logic     run_last;
   } codec_byte_t;

   // one row of the directed table; typed rows carry their results, the rest use the predictor
   typedef struct packed {
      dir_type    dir;
      byte_type   data;
      logic       msg_end;
      logic       typed;
      logic [1:0] n;
      byte_type   e0;
      byte_type   e1;
      byte_type   e2;
   } directed_row_t;

   localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
      // encode: plain byte, every escape class, a plain control byte, message end
      '{DIR_ENCODE, CHAR_A,     1'b0, 1'b1, 2'd1, CHAR_A,     8'h00,     8'h00},
      '{DIR_ENCODE, CHAR_COLON, 1'b0, 1'b1, 2'd2, CHAR_COLON, CHAR_COLON, 8'h00},
      '{DIR_ENCODE, 8'h00,      1'b0, 1'b1, 2'd2, CHAR_COLON, CHAR_ZERO, 8'h00},
      '{DIR_ENCODE, 8'h09,      1'b0, 1'b1, 2'd2, CHAR_COLON, CHAR_NINE, 8'h00},
      '{DIR_ENCODE, CHAR_LF,    1'b0, 1'b1, 2'd2, CHAR_COLON, CHAR_A,    8'h00},
      '{DIR_ENCODE, CHAR_CR,    1'b0, 1'b1, 2'd2, CHAR_COLON, CHAR_B,    8'h00},
      '{DIR_ENCODE, CHAR_CARET, 1'b0, 1'b1, 2'd2, CHAR_COLON, CHAR_C,    8'h00},
      '{DIR_ENCODE, CHAR_DEL,   1'b0, 1'b1, 2'd2, CHAR_COLON, CHAR_D,    8'h00},
      '{DIR_ENCODE, CHAR_FF,    1'b0, 1'b1, 2'd2, CHAR_COLON, CHAR_E,    8'h00},
      '{DIR_ENCODE, 8'h0B,      1'b0, 1'b0, 2'd0, 8'h00,      8'h00,     8'h00},
      '{DIR_ENCODE, 8'h80,      1'b1, 1'b0, 2'd0, 8'h00,      8'h00,     8'h00},
      // decode: line feed between colon and code keeps the colon pending
      '{DIR_DECODE, CHAR_COLON, 1'b0, 1'b1, 2'd0, 8'h00,      8'h00,     8'h00},
      '{DIR_DECODE, CHAR_LF,    1'b0, 1'b1, 2'd0, 8'h00,      8'h00,     8'h00},
      '{DIR_DECODE, CHAR_E,     1'b0, 1'b1, 2'd1, CHAR_FF,    8'h00,     8'h00},
      // unknown code swallows both bytes
      '{DIR_DECODE, CHAR_COLON, 1'b0, 1'b1, 2'd0, 8'h00,      8'h00,     8'h00},
      '{DIR_DECODE, 8'h5A,      1'b0, 1'b1, 2'd0, 8'h00,      8'h00,     8'h00},
      '{DIR_DECODE, CHAR_COLON, 1'b0, 1'b1, 2'd0, 8'h00,      8'h00,     8'h00},
      '{DIR_DECODE, CHAR_NINE,  1'b0, 1'b1, 2'd1, 8'h09,      8'h00,     8'h00},
      '{DIR_DECODE, 8'h00,      1'b0, 1'b1, 2'd1, 8'h00,      8'h00,     8'h00},
      '{DIR_DECODE, 8'hFE,      1'b0, 1'b0, 2'd0, 8'h00,      8'h00,     8'h00},
      // lone colon at message end is dropped and cleared
      '{DIR_DECODE, CHAR_COLON, 1'b1, 1'b1, 2'd0, 8'h00,      8'h00,     8'h00},
      // colon pending across a trip through encode: direction change keeps state
      '{DIR_DECODE, CHAR_COLON, 1'b0, 1'b1, 2'd0, 8'h00,      8'h00,     8'h00},
      '{DIR_ENCODE, 8'h7E,      1'b0, 1'b0, 2'd0, 8'h00,      8'h00,     8'h00},
      '{DIR_DECODE, CHAR_A,     1'b1, 1'b1, 2'd1, CHAR_LF,    8'h00,     8'h00}
   };

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   byte_type              req_data_byte;
   logic                  req_message_end;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   byte_type              rsp_out_byte;
   logic                  rsp_run_last;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0]           pwdata;
   logic [31:0]           prdata;
   logic                  pready;

   // predictor state, kept apart from the block
   dir_type               cfg_dir = DIR_ENCODE;
   logic [6:0]            enc_line_fill = 7'd0;
   logic                  dec_colon_seen = 1'b0;

   codec_byte_t           pending_bytes [$];
   int unsigned           mismatch_count = 0;
   int unsigned           stim_count = 0;
   int unsigned           cycle_count = 0;
   // set while neither side may idle
   bit                    steady = 1'b0;

   colon_escape_byte_codec #(.LINE_LEN(LINE_LEN)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_message_end (req_message_end),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_run_last    (rsp_run_last),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_colon_escape_byte_codec: errors");
         $finish;
      end
   end

   task automatic note_mismatch(input string what, input int unsigned want,
                                input int unsigned got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch: %s expected %0h got %0h", what, want, got);
   endtask

   // raw byte to {escaped, code character}
   function automatic logic [8:0] raw_to_code(input byte_type d);
      if (d < 8'h0A) return {1'b1, CHAR_ZERO | d};
      case (d)
         CHAR_COLON: return {1'b1, CHAR_COLON};
         CHAR_LF:    return {1'b1, CHAR_A};
         CHAR_CR:    return {1'b1, CHAR_B};
         CHAR_CARET: return {1'b1, CHAR_C};
         CHAR_DEL:   return {1'b1, CHAR_D};
         CHAR_FF:    return {1'b1, CHAR_E};
         default:    return 9'h000;
      endcase
   endfunction

   // code character to {known, raw byte}
   function automatic logic [8:0] code_to_raw(input byte_type c);
      if (c >= CHAR_ZERO && c <= CHAR_NINE) return {1'b1, c & 8'h0F};
      case (c)
         CHAR_COLON: return {1'b1, CHAR_COLON};
         CHAR_A:     return {1'b1, CHAR_LF};
         CHAR_B:     return {1'b1, CHAR_CR};
         CHAR_C:     return {1'b1, CHAR_CARET};
         CHAR_D:     return {1'b1, CHAR_DEL};
         CHAR_E:     return {1'b1, CHAR_FF};
         default:    return 9'h000;
      endcase
   endfunction

   // bytes produced by one input item under the current direction; advances the state
   function automatic void codec_expand(input byte_type d, input logic msg_end,
                                        output byte_type res [3], output int unsigned cnt);
      byte_type   seq [2];
      int unsigned m;
      logic       lf_done;
      logic [8:0] map;
      cnt     = 0;
      lf_done = 1'b0;
      res     = '{default: 8'h00};
      if (cfg_dir == DIR_ENCODE) begin
         map = raw_to_code(d);
         if (map[8]) begin
            seq[0] = CHAR_COLON;
            seq[1] = map[7:0];
            m      = 2;
         end else begin
            seq[0] = d;
            seq[1] = 8'h00;
            m      = 1;
         end
         for (int k = 0; k < m; k++) begin
            // at most one wrap per item, even on one-byte lines
            if (enc_line_fill >= LINE_LEN && !lf_done) begin
               res[cnt] = CHAR_LF;
               cnt++;
               enc_line_fill = 7'd0;
               lf_done = 1'b1;
            end
            res[cnt] = seq[k];
            cnt++;
            if (enc_line_fill != 7'd127) enc_line_fill++;
         end
      end else if (d != CHAR_LF) begin
         if (dec_colon_seen) begin
            dec_colon_seen = 1'b0;
            map = code_to_raw(d);
            if (map[8]) begin
               res[cnt] = map[7:0];
               cnt++;
            end
         end else if (d == CHAR_COLON) begin
            dec_colon_seen = 1'b1;
         end else begin
            res[cnt] = d;
            cnt++;
         end
      end
      if (msg_end) begin
         enc_line_fill  = 7'd0;
         dec_colon_seen = 1'b0;
      end
   endfunction

   // offer one item, hold it until accepted, then book what it should produce
   task automatic send_item(input byte_type d, input logic msg_end, input logic typed = 1'b0,
                            input logic [1:0] n = 2'd0, input logic [23:0] typed_bytes = 24'h0);
      byte_type    res [3];
      int unsigned cnt;
      codec_byte_t entry;
      // idle a random number of cycles, each with the idle probability
      if (!steady) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid       <= 1'b1;
      req_data_byte   <= d;
      req_message_end <= msg_end;
      do @(posedge clock); while (!req_ready);
      codec_expand(d, msg_end, res, cnt);
      // typed rows override the predictor with hand-read values
      if (typed) begin
         cnt    = n;
         res[0] = typed_bytes[23:16];
         res[1] = typed_bytes[15:8];
         res[2] = typed_bytes[7:0];
      end
      for (int k = 0; k < cnt; k++) begin
         entry.out_byte = res[k];
         entry.run_last = (k == cnt - 1);
         pending_bytes.push_back(entry);
      end
      // dropped line feeds in decode produce nothing and are not counted
      if (!(cfg_dir == DIR_DECODE && d == CHAR_LF)) stim_count++;
   endtask

   // stop offering items and let the pipeline empty
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // apb setup then access phase; pready is tied high so the access phase never waits
   task automatic csr_access(input logic wr, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= addr;
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic check_direction();
      logic [31:0] rdata;
      csr_access(1'b0, CSR_ADDR_W'(4 * REG_DIRECTION), 32'h0, rdata);
      if (rdata != 32'(cfg_dir)) note_mismatch("direction readback", 32'(cfg_dir), rdata);
   endtask

   task automatic write_direction(input dir_type dir);
      logic [31:0] rdata;
      csr_access(1'b1, CSR_ADDR_W'(4 * REG_DIRECTION), 32'(dir), rdata);
      cfg_dir = dir;
      check_direction();
   endtask

   // one of the bytes that encode must escape
   function automatic byte_type special_raw();
      int unsigned k;
      k = $urandom_range(0, 15);
      if (k <= 10) return byte_type'(k);
      case (k)
         11:      return CHAR_CR;
         12:      return CHAR_CARET;
         13:      return CHAR_DEL;
         14:      return CHAR_FF;
         default: return CHAR_COLON;
      endcase
   endfunction

   // one valid escape code character
   function automatic byte_type valid_code();
      int unsigned k;
      k = $urandom_range(0, 15);
      if (k <= 9) return CHAR_ZERO + byte_type'(k);
      if (k <= 14) return CHAR_A + byte_type'(k - 10);
      return CHAR_COLON;
   endfunction

   // result side: random stall plus in-order compare against the expectation queue
   always @(posedge clock) begin
      codec_byte_t want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_bytes.size() == 0) begin
            note_mismatch("unexpected result byte", 0, rsp_out_byte);
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_out_byte !== want.out_byte)
               note_mismatch("out_byte", want.out_byte, rsp_out_byte);
            if (rsp_run_last !== want.run_last)
               note_mismatch("run_last", want.run_last, rsp_run_last);
         end
      end
   end

   initial begin
      directed_row_t row;
      dir_type       dir;
      int unsigned   target;
      int unsigned   r;
      logic          msg_end;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_data_byte   = 8'h00;
      req_message_end = 1'b0;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = '0;
      pwdata          = 32'h0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register must come out of reset in encode
      check_direction();

      // directed table, with a drain and direction write wherever a row switches mode
      for (int i = 0; i < NUM_DIRECTED; i++) begin
         row = DIRECTED_ROWS[i];
         if (row.dir != cfg_dir) begin
            settle();
            write_direction(row.dir);
         end
         send_item(row.data, row.msg_end, row.typed, row.n, {row.e0, row.e1, row.e2});
      end

      // random phases, alternating direction; encode phases run long enough to wrap lines
      target = stim_count;
      for (int phase = 0; phase < 4; phase++) begin
         dir = (phase % 2 == 0) ? DIR_ENCODE : DIR_DECODE;
         settle();
         write_direction(dir);
         target += (dir == DIR_ENCODE) ? 62 : 40;
         while (stim_count < target) begin
            // long stretch of back-to-back traffic early in the second encode phase
            steady = (phase == 2) && (target - stim_count > 30);
            if (dir == DIR_ENCODE) begin
               // rare message ends so lines fill past the wrap point
               msg_end = ($urandom_range(99) < 2);
               if ($urandom_range(99) < 35) send_item(special_raw(), msg_end);
               else send_item(byte_type'($urandom_range(255)), msg_end);
            end else begin
               msg_end = ($urandom_range(99) < 8);
               r = $urandom_range(99);
               if (r < 55) begin
                  // well-formed escape pair, sometimes split by a line feed
                  send_item(CHAR_COLON, 1'b0);
                  if ($urandom_range(99) < 10) send_item(CHAR_LF, 1'b0);
                  send_item(valid_code(), msg_end);
               end else if (r < 75) begin
                  send_item(byte_type'($urandom_range(255)), msg_end);
               end else if (r < 83) begin
                  send_item(CHAR_LF, msg_end);
               end else if (r < 93) begin
                  // colon with an arbitrary code, mostly unknown
                  send_item(CHAR_COLON, 1'b0);
                  send_item(byte_type'($urandom_range(255)), msg_end);
               end else begin
                  send_item(CHAR_COLON, 1'b1);
               end
            end
         end
      end
      steady = 1'b0;

      settle();
      if (mismatch_count == 0) begin
         $display("tb_colon_escape_byte_codec: clean");
      end else begin
         $display("tb_colon_escape_byte_codec: errors");
      end
      $finish;
   end

endmodule
`default_nettype wire
